[src/window_mean_stddev_threshold_assert.svh]
// Assertion macros for the window statistics block.
// Each use names a label and a property expression without commas.
`ifndef WINDOW_MEAN_STDDEV_THRESHOLD_ASSERT_SVH
`define WINDOW_MEAN_STDDEV_THRESHOLD_ASSERT_SVH

// Check on every edge outside reset.
`define WMST_CHECK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("window statistics check failed");

// Check on every edge, reset included.
`define WMST_CHECK_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("window statistics check failed during or after reset");

`endif

[src/wmst_pkg.sv]
`default_nettype none

package wmst_pkg;

	// Window geometry (WINDOW must be a power of two)
	localparam int WINDOW      = 128;
	localparam int WIN_BITS    = $clog2(WINDOW);
	localparam int SAMPLE_BITS = 12;
	localparam int SUM_BITS    = SAMPLE_BITS + WIN_BITS;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;
	localparam int SQSUM_BITS  = SQ_BITS + WIN_BITS;
	localparam int ROOT_BITS   = SAMPLE_BITS;
	localparam int CNT_BITS    = WIN_BITS + 1;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 12;

	localparam logic [CFG_IDX_BITS-1:0] REG_BASE_THR   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACT_THR    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACT_LEVEL  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_REST_LEVEL = 3'd3;

	localparam logic [11:0] RST_BASE_THR   = 12'd1500;
	localparam logic [11:0] RST_ACT_THR    = 12'd1500;
	localparam logic [7:0]  RST_ACT_LEVEL  = 8'd20;
	localparam logic [7:0]  RST_REST_LEVEL = 8'd10;

	// Frame layout
	localparam logic [7:0]  BYTE_OPEN  = 8'h03;
	localparam logic [7:0]  BYTE_CLOSE = 8'hFC;
	localparam logic [12:0] THR_MAX    = 13'h1FFF;

	localparam logic [2:0] POS_OPEN    = 3'd0;
	localparam logic [2:0] POS_MON_LO  = 3'd1;
	localparam logic [2:0] POS_MON_HI  = 3'd2;
	localparam logic [2:0] POS_MEAN_LO = 3'd3;
	localparam logic [2:0] POS_MEAN_HI = 3'd4;
	localparam logic [2:0] POS_CLOSE   = 3'd5;

	typedef struct packed {
		logic [11:0] window_sample;
		logic [11:0] monitor_sample;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        last_byte;
		logic [11:0] window_mean;
		logic [12:0] deviation_threshold;
		logic [7:0]  drive_level;
	} out_item_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SUM  = 6'b000010,
		ST_SQ   = 6'b000100,
		ST_ROOT = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_SEND = 6'b100000
	} state_t;

endpackage

`default_nettype wire

[src/wmst_ram.sv]
`default_nettype none

module wmst_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[src/window_mean_stddev_threshold.sv]
// Takes one item at a time: a new input is accepted only in idle, after the last
// frame's closing byte; each item makes two passes over the 128-entry window RAM
// (one read port), a 12-step root and the six-byte frame.
// Reset (arst_n low): window reads as all zeros through per-entry valid bits,
// write pointer zero, registers at 1500 / 1500 / 20 / 10, no frame pending.
`default_nettype none

`include "window_mean_stddev_threshold_assert.svh"

module window_mean_stddev_threshold (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire wmst_pkg::in_item_t                   in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output wmst_pkg::out_item_t                       out_data,
	input  wire logic                                 cfg_we,
	input  wire logic [wmst_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  wire logic [wmst_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	wmst_pkg::state_t                      state_q;
	logic [wmst_pkg::CNT_BITS-1:0]         idx_q;      // read address, root step, byte position
	logic [wmst_pkg::WIN_BITS-1:0]         wp_q;       // next ring slot to write
	logic [wmst_pkg::WINDOW-1:0]           valid_q;    // entry written since reset
	logic                                  rd_s1;      // RAM data valid this cycle
	logic                                  prod_vld_s2;

	// Configuration registers
	logic [11:0] base_thr_q;
	logic [11:0] act_thr_q;
	logic [7:0]  act_level_q;
	logic [7:0]  rest_level_q;

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	logic [11:0]                           mon_q;
	logic [wmst_pkg::SUM_BITS-1:0]         sum_q;
	logic [wmst_pkg::SAMPLE_BITS-1:0]      mean_q;
	logic [wmst_pkg::SQ_BITS-1:0]          prod_s2;
	logic [wmst_pkg::SQSUM_BITS-1:0]       sumsq_q;
	logic [wmst_pkg::SQ_BITS-1:0]          rad_q;
	logic [wmst_pkg::ROOT_BITS:0]          rem_q;
	logic [wmst_pkg::ROOT_BITS-1:0]        root_q;
	logic [12:0]                           thr_q;
	logic [7:0]                            drive_q;
	logic                                  vld_s1;

	// ------------------------------------------------------------------
	// Window RAM: written once per item, read twice over per item
	// ------------------------------------------------------------------
	logic                                  in_xfer;
	logic                                  out_xfer;
	logic                                  issue;
	logic [wmst_pkg::WIN_BITS-1:0]         raddr;
	logic [wmst_pkg::SAMPLE_BITS-1:0]      ram_rdata;
	logic [wmst_pkg::SAMPLE_BITS-1:0]      sample_s1;
	logic [wmst_pkg::SAMPLE_BITS-1:0]      diff_s1;
	logic                                  pass_end;
	logic                                  root_last;
	logic [2:0]                            pos;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign raddr    = idx_q[wmst_pkg::WIN_BITS-1:0];
	assign issue    = (idx_q != wmst_pkg::CNT_BITS'(wmst_pkg::WINDOW));
	assign pass_end = !issue && !rd_s1 && !prod_vld_s2;
	assign root_last = (idx_q == wmst_pkg::CNT_BITS'(wmst_pkg::ROOT_BITS - 1));
	assign pos      = idx_q[2:0];

	wmst_ram #(
		.WIDTH (wmst_pkg::SAMPLE_BITS),
		.DEPTH (wmst_pkg::WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (wp_q),
		.wdata (in_data.window_sample[wmst_pkg::SAMPLE_BITS-1:0]),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// A slot never written since reset counts as zero
	assign sample_s1 = vld_s1 ? ram_rdata : '0;
	assign diff_s1   = (sample_s1 >= mean_q) ? (sample_s1 - mean_q) : (mean_q - sample_s1);

	// ------------------------------------------------------------------
	// Square root step: two radicand bits in, one root bit out
	// ------------------------------------------------------------------
	logic [wmst_pkg::ROOT_BITS+2:0] rem_sh;
	logic [wmst_pkg::ROOT_BITS+2:0] trial;
	logic                           take;

	assign rem_sh = {rem_q, rad_q[wmst_pkg::SQ_BITS-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	// Threshold with saturation
	logic [13:0] thr_sum;
	assign thr_sum = 14'(base_thr_q) + 14'(root_q);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wmst_pkg::ST_IDLE;
			idx_q       <= '0;
			wp_q        <= '0;
			valid_q     <= '0;
			rd_s1       <= 1'b0;
			prod_vld_s2 <= 1'b0;
		end else begin
			unique case (state_q)
				wmst_pkg::ST_IDLE: begin
					// store the sample and mark its slot, then start the mean pass
					if (in_xfer) begin
						valid_q[wp_q] <= 1'b1;
						wp_q          <= wp_q + 1'b1;
						idx_q         <= '0;
						state_q       <= wmst_pkg::ST_SUM;
					end
				end
				wmst_pkg::ST_SUM: begin
					rd_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (pass_end) begin
						idx_q   <= '0;
						state_q <= wmst_pkg::ST_SQ;
					end
				end
				wmst_pkg::ST_SQ: begin
					rd_s1       <= issue;
					prod_vld_s2 <= rd_s1;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (pass_end) begin
						idx_q   <= '0;
						state_q <= wmst_pkg::ST_ROOT;
					end
				end
				wmst_pkg::ST_ROOT: begin
					idx_q <= idx_q + 1'b1;
					if (root_last) begin
						state_q <= wmst_pkg::ST_FIN;
					end
				end
				wmst_pkg::ST_FIN: begin
					idx_q   <= '0;
					state_q <= wmst_pkg::ST_SEND;
				end
				wmst_pkg::ST_SEND: begin
					// advance one byte per transfer; drop back to idle after the closing byte
					if (out_xfer) begin
						if (pos == wmst_pkg::POS_CLOSE) begin
							state_q <= wmst_pkg::ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= wmst_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_thr_q   <= wmst_pkg::RST_BASE_THR;
			act_thr_q    <= wmst_pkg::RST_ACT_THR;
			act_level_q  <= wmst_pkg::RST_ACT_LEVEL;
			rest_level_q <= wmst_pkg::RST_REST_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				wmst_pkg::REG_BASE_THR:   base_thr_q   <= cfg_wdata[11:0];
				wmst_pkg::REG_ACT_THR:    act_thr_q    <= cfg_wdata[11:0];
				wmst_pkg::REG_ACT_LEVEL:  act_level_q  <= cfg_wdata[7:0];
				wmst_pkg::REG_REST_LEVEL: rest_level_q <= cfg_wdata[7:0];
				default: begin
					// index past the register list: ignore
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath (no reset needed)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		vld_s1  <= valid_q[raddr];
		prod_s2 <= wmst_pkg::SQ_BITS'(diff_s1) * wmst_pkg::SQ_BITS'(diff_s1);

		case (state_q)
			wmst_pkg::ST_IDLE: begin
				if (in_xfer) begin
					mon_q <= in_data.monitor_sample;
					sum_q <= '0;
				end
			end
			wmst_pkg::ST_SUM: begin
				if (rd_s1) begin
					sum_q <= sum_q + wmst_pkg::SUM_BITS'(sample_s1);
				end
				// floor mean is a plain shift of the window sum
				if (pass_end) begin
					mean_q  <= sum_q[wmst_pkg::SUM_BITS-1:wmst_pkg::WIN_BITS];
					sumsq_q <= '0;
				end
			end
			wmst_pkg::ST_SQ: begin
				if (prod_vld_s2) begin
					sumsq_q <= sumsq_q + wmst_pkg::SQSUM_BITS'(prod_s2);
				end
				if (pass_end) begin
					rad_q  <= sumsq_q[wmst_pkg::SQSUM_BITS-1:wmst_pkg::WIN_BITS];
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			wmst_pkg::ST_ROOT: begin
				rad_q <= {rad_q[wmst_pkg::SQ_BITS-3:0], 2'b00};
				if (take) begin
					rem_q  <= (wmst_pkg::ROOT_BITS+1)'(rem_sh - trial);
					root_q <= {root_q[wmst_pkg::ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[wmst_pkg::ROOT_BITS:0];
					root_q <= {root_q[wmst_pkg::ROOT_BITS-2:0], 1'b0};
				end
			end
			wmst_pkg::ST_FIN: begin
				thr_q   <= (thr_sum > 14'(wmst_pkg::THR_MAX)) ? wmst_pkg::THR_MAX
				                                              : thr_sum[12:0];
				drive_q <= (12'(mean_q) > act_thr_q) ? act_level_q : rest_level_q;
			end
			default: begin
				// hold
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Frame output: fields come straight from held registers
	// ------------------------------------------------------------------
	logic [7:0] tx_byte;

	always_comb begin
		unique case (pos)
			wmst_pkg::POS_OPEN:    tx_byte = wmst_pkg::BYTE_OPEN;
			wmst_pkg::POS_MON_LO:  tx_byte = mon_q[7:0];
			wmst_pkg::POS_MON_HI:  tx_byte = 8'(mon_q >> 8);
			wmst_pkg::POS_MEAN_LO: tx_byte = 8'(mean_q);
			wmst_pkg::POS_MEAN_HI: tx_byte = 8'(mean_q >> 8);
			wmst_pkg::POS_CLOSE:   tx_byte = wmst_pkg::BYTE_CLOSE;
			default:               tx_byte = wmst_pkg::BYTE_CLOSE;
		endcase
	end

	assign in_ready  = (state_q == wmst_pkg::ST_IDLE);
	assign out_valid = (state_q == wmst_pkg::ST_SEND);

	always_comb begin
		out_data.tx_byte             = tx_byte;
		out_data.last_byte           = (pos == wmst_pkg::POS_CLOSE);
		out_data.window_mean         = 12'(mean_q);
		out_data.deviation_threshold = thr_q;
		out_data.drive_level         = drive_q;
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Case inequality keeps the check quiet before the first reset edge settles the state.
	`WMST_CHECK_ALWAYS(a_no_overlap, (in_ready && out_valid) !== 1'b1)
	`WMST_CHECK(a_last_is_close, (out_valid && out_data.last_byte) |-> (out_data.tx_byte == wmst_pkg::BYTE_CLOSE))
	`WMST_CHECK(a_idle_after_frame, (out_xfer && out_data.last_byte) |=> in_ready)
	`WMST_CHECK(a_wp_advance, in_xfer |=> (wp_q == wmst_pkg::WIN_BITS'($past(wp_q) + 1'b1)))

endmodule

`default_nettype wire
